// File: design/wireframe_path_vertex_lerp_core_macros.svh
// Assertion macros for the wireframe vertex interpolator.
// Used by wireframe_path_vertex_lerp_core; expects clk_i and rst_ni in scope.
`ifndef WIREFRAME_PATH_VERTEX_LERP_CORE_MACROS_SVH
`define WIREFRAME_PATH_VERTEX_LERP_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define WPVL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define WPVL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wpvl_pkg.sv
// Shared types and constants for the wireframe vertex interpolator.
// No dependencies; used by wireframe_path_vertex_lerp_core.
`timescale 1ns / 1ps

package wpvl_pkg;

  localparam int unsigned FIELD_W = 24;
  localparam int unsigned ORDER_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_OFFSET      = 3'd0,
    REG_Y_OFFSET      = 3'd1,
    REG_Z_OFFSET      = 3'd2,
    REG_X_GAIN        = 3'd3,
    REG_Y_GAIN        = 3'd4,
    REG_Z_GAIN        = 3'd5,
    REG_SEGMENT_ORDER = 3'd6
  } cfg_reg_e;

  // Reset values
  localparam logic signed [FIELD_W-1:0] OFFSET_RST = 24'sd0;
  localparam logic signed [FIELD_W-1:0] GAIN_RST   = 24'sd65536;
  localparam logic [ORDER_W-1:0]        ORDER_RST  = 16'd20007;

  // Saturation limits of a 24-bit signed coordinate
  localparam int SAT_MAX = 8388607;
  localparam int SAT_MIN = -8388608;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] phase;
    logic signed [FIELD_W-1:0] interp_amount;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;
    logic signed [FIELD_W-1:0] z_coord;
  } out_word_t;

endpackage

// File: design/wireframe_path_vertex_lerp_core.sv
// Wireframe vertex interpolator: one X/Y/Z point on a tetrahedron outline per word.
// Depends on wpvl_pkg and wireframe_path_vertex_lerp_core_macros.svh.
`timescale 1ns / 1ps

// Takes one word per clock while the output is not stalled and returns one point
// per word. Four register stages (phase multiply and vertex pick, lerp multiply,
// gain multiply, offset and saturate) each hold a valid bit and move on their
// own, so a bubble closes up and a stall on the output holds every stage without
// loss. Sustained rate is one word per cycle while the output accepts, set by the
// single multiplier per lane in each stage. Configuration writes take effect at
// once and should only be made while the pipeline is empty.
`include "wireframe_path_vertex_lerp_core_macros.svh"

module wireframe_path_vertex_lerp_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input word channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  wpvl_pkg::in_word_t                  in_word_i,
  // output word channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output wpvl_pkg::out_word_t                 out_word_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [wpvl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wpvl_pkg::FIELD_W-1:0]        cfg_wdata_i
);

  localparam int unsigned FW = wpvl_pkg::FIELD_W;
  // vertex and difference width, product widths
  localparam int unsigned VW = FRAC_BITS + 3;
  localparam int unsigned PW = FRAC_BITS + 1 + FW;
  localparam int unsigned MW = 2 * FRAC_BITS + 4;
  localparam int unsigned GW = VW + FW;

  // vertex constants at FRAC_BITS, rounded to nearest
  localparam longint C_ONE_L  = longint'(1) << FRAC_BITS;
  localparam longint C_R3H_L  = ((longint'(866025) << FRAC_BITS) + 500000) / 1000000;
  localparam longint C_3Q_L   = (3 * C_ONE_L) / 4;
  localparam longint C_HALF_L = C_ONE_L / 2;

  localparam logic signed [VW-1:0] C_ONE   = VW'(C_ONE_L);
  localparam logic signed [VW-1:0] C_R3H   = VW'(C_R3H_L);
  localparam logic signed [VW-1:0] C_3Q    = VW'(C_3Q_L);
  localparam logic signed [VW-1:0] C_HALF  = VW'(C_HALF_L);
  localparam logic signed [VW-1:0] C_ZERO  = '0;

  localparam logic signed [GW-1:0] SAT_HI = GW'(wpvl_pkg::SAT_MAX);
  localparam logic signed [GW-1:0] SAT_LO = GW'(wpvl_pkg::SAT_MIN);

  // vertex table: one coordinate of one of the four corners
  function automatic logic signed [VW-1:0] vtx(input logic [1:0] v, input logic [1:0] ax);
    logic signed [VW-1:0] r;
    r = C_ZERO;
    case (ax)
      wpvl_pkg::AXIS_X: begin
        case (v)
          2'd1:    r = C_R3H;
          2'd2:    r = -C_R3H;
          default: r = C_ZERO;
        endcase
      end
      wpvl_pkg::AXIS_Y: begin
        case (v)
          2'd0:    r = C_ONE;
          2'd3:    r = C_ZERO;
          default: r = -C_HALF;
        endcase
      end
      wpvl_pkg::AXIS_Z: begin
        case (v)
          2'd3:    r = C_3Q;
          default: r = -C_3Q;
        endcase
      end
      default: r = C_ZERO;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [FW-1:0]               off_q  [3];
  logic signed [FW-1:0]               gain_q [3];
  logic [wpvl_pkg::ORDER_W-1:0]       order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        off_q[k]  <= wpvl_pkg::OFFSET_RST;
        gain_q[k] <= wpvl_pkg::GAIN_RST;
      end
      order_q <= wpvl_pkg::ORDER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wpvl_pkg::REG_X_OFFSET:      off_q[0]  <= cfg_wdata_i;
        wpvl_pkg::REG_Y_OFFSET:      off_q[1]  <= cfg_wdata_i;
        wpvl_pkg::REG_Z_OFFSET:      off_q[2]  <= cfg_wdata_i;
        wpvl_pkg::REG_X_GAIN:        gain_q[0] <= cfg_wdata_i;
        wpvl_pkg::REG_Y_GAIN:        gain_q[1] <= cfg_wdata_i;
        wpvl_pkg::REG_Z_GAIN:        gain_q[2] <= cfg_wdata_i;
        wpvl_pkg::REG_SEGMENT_ORDER: order_q   <= cfg_wdata_i[wpvl_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: each stage loads when empty or when it is moving on
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: wrap phase, pick segment vertices, fraction of phase * amount
  // ---------------------------------------------------------------------------
  logic [FRAC_BITS-1:0]     t_s1;
  logic [2:0]               seg_s1, nxt_s1;
  logic [1:0]               va_s1, vb_s1;
  logic signed [PW-1:0]     tprod_s1;
  logic [FRAC_BITS-1:0]     f1_q;
  logic signed [VW-1:0]     a1_q [3];
  logic signed [VW-1:0]     d1_q [3];

  always_comb begin
    t_s1     = in_word_i.phase[FRAC_BITS-1:0];
    seg_s1   = t_s1[FRAC_BITS-1 -: 3];
    nxt_s1   = seg_s1 + 3'd1;
    va_s1    = 2'(order_q >> {seg_s1, 1'b0});
    vb_s1    = 2'(order_q >> {nxt_s1, 1'b0});
    // (8t * amount) mod 2^(2F) seen through t * amount shifted by three
    tprod_s1 = PW'($signed({1'b0, t_s1})) * PW'(in_word_i.interp_amount);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      f1_q <= tprod_s1[2*FRAC_BITS-4 : FRAC_BITS-3];
      for (int k = 0; k < 3; k++) begin
        a1_q[k] <= vtx(va_s1, 2'(k));
        d1_q[k] <= vtx(vb_s1, 2'(k)) - vtx(va_s1, 2'(k));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: fraction times vertex difference
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] m2_q [3];
  logic signed [VW-1:0] a2_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      for (int k = 0; k < 3; k++) begin
        m2_q[k] <= MW'($signed({1'b0, f1_q})) * MW'(d1_q[k]);
        a2_q[k] <= a1_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: point on the edge, then gain
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] pw_s3 [3];
  logic signed [VW-1:0] p_s3  [3];
  logic signed [GW-1:0] g3_q  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pw_s3[k] = MW'(a2_q[k]) + (m2_q[k] >>> FRAC_BITS);
      p_s3[k]  = $signed(pw_s3[k][VW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      for (int k = 0; k < 3; k++) begin
        g3_q[k] <= GW'(p_s3[k]) * GW'(gain_q[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: floor to Q format, add offset, saturate
  // ---------------------------------------------------------------------------
  logic signed [GW-1:0] sum_s4 [3];
  logic signed [FW-1:0] sat_s4 [3];
  logic signed [FW-1:0] xo_q   [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_s4[k] = (g3_q[k] >>> FRAC_BITS) + GW'(off_q[k]);
      if (sum_s4[k] > SAT_HI) begin
        sat_s4[k] = FW'(SAT_HI);
      end else if (sum_s4[k] < SAT_LO) begin
        sat_s4[k] = FW'(SAT_LO);
      end else begin
        sat_s4[k] = sum_s4[k][FW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      for (int k = 0; k < 3; k++) begin
        xo_q[k] <= sat_s4[k];
      end
    end
  end

  assign out_word_o.x_coord = xo_q[0];
  assign out_word_o.y_coord = xo_q[1];
  assign out_word_o.z_coord = xo_q[2];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `WPVL_ASSERT_NEXT(a_accept_fills_s1, in_valid_i && in_ready_o, v1_q,
    "accepted word did not reach stage 1")
  `WPVL_ASSERT_NEXT(a_s3_to_out, v3_q && rdy4, out_valid_o,
    "stage 3 word lost on its way to the output")
  `WPVL_ASSERT_NOW(a_empty_out_ready, !out_valid_o, in_ready_o,
    "input stalled while the output register is empty")

endmodule
